@@ rtl/core/spf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared widths, codes, reset values and types of the strip peak finder.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int CHANNELS_DEF = 1024;
   localparam int SAMPLES_DEF  = 32;

   localparam int CHAN_W     = 10;
   localparam int AMP_W      = 13;
   localparam int PEAK_W     = 12;
   localparam int NOISE_W    = 16;
   localparam int INDEX_W    = 5;
   localparam int TIME_W     = 14;
   localparam int THR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_W      = 14;
   localparam int DEN_W      = 15;
   localparam int DIVIDEND_W = 21;
   localparam int DIVISOR_W  = 14;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_SIGMAS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_AMPLITUDE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_NOISE        = 2'd2;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd72;
   localparam logic [PEAK_W-1:0]  MIN_AMP_RESET   = 12'd20;
   localparam logic [NOISE_W-1:0] MIN_NOISE_RESET = 16'd64;

   localparam logic [TIME_W-1:0] TIME_HALF   = 14'd128;
   localparam logic [TIME_W-1:0] TIME_NO_FIT = 14'h3F00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [PEAK_W-1:0]       running_max;
      logic signed [AMP_W-1:0] lead;
      logic signed [AMP_W-1:0] trail;
      logic                    after_pending;
   } track_type;

endpackage
`default_nettype wire

@@ rtl/core/spf_track.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_track
// Running maximum of one channel, with its first index and its neighbors.
// ----------------------------------------------------------------------------
module spf_track #(
   parameter int SAMPLES = spf_pkg::SAMPLES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            sample_en,
   input  wire logic signed [spf_pkg::AMP_W-1:0] sample,
   input  wire logic                            clear_en,
   output spf_pkg::track_type                   status,
   output logic [$clog2(SAMPLES)-1:0]           max_pos
);
   import spf_pkg::*;

   localparam int PosW = $clog2(SAMPLES);
   localparam int CntW = $clog2(SAMPLES + 1);

   logic [PEAK_W-1:0]       max_ff, max_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic signed [AMP_W-1:0] before_ff, before_in;
   logic signed [AMP_W-1:0] after_ff, after_in;
   logic signed [AMP_W-1:0] prev_ff, prev_in;
   logic [CntW-1:0]         count_ff, count_in;
   logic                    pend_ff, pend_in;
   logic                    greater;

   always_comb begin
      greater   = sample > $signed({1'b0, max_ff});
      max_in    = max_ff;
      pos_in    = pos_ff;
      before_in = before_ff;
      after_in  = after_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      if (clear_en) begin
         max_in    = '0;
         pos_in    = '0;
         before_in = '0;
         after_in  = '0;
         prev_in   = '0;
         count_in  = '0;
         pend_in   = 1'b0;
      end else if (sample_en && (count_ff < CntW'(SAMPLES))) begin
         if (pend_ff) begin
            after_in = sample;
         end
         pend_in = greater;
         if (greater) begin
            max_in    = sample[PEAK_W-1:0];
            pos_in    = count_ff[PosW-1:0];
            before_in = prev_ff;
         end
         prev_in  = sample;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= '0;
         pos_ff    <= '0;
         before_ff <= '0;
         after_ff  <= '0;
         prev_ff   <= '0;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         max_ff    <= max_in;
         pos_ff    <= pos_in;
         before_ff <= before_in;
         after_ff  <= after_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
      end
   end

   assign status.running_max   = max_ff;
   assign status.lead          = before_ff;
   assign status.trail         = after_ff;
   assign status.after_pending = pend_ff;
   assign max_pos              = pos_ff;

endmodule
`default_nettype wire

@@ rtl/core/spf_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [spf_pkg::DIVIDEND_W-1:0]    dividend,
   input  wire logic [spf_pkg::DIVISOR_W-1:0]     divisor,
   output logic                                   done,
   output logic [spf_pkg::DIVIDEND_W-1:0]         quotient
);
   import spf_pkg::*;

   localparam int StepW = $clog2(DIVIDEND_W);
   localparam logic [StepW-1:0] LastStep = StepW'(DIVIDEND_W - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic [DIVISOR_W-1:0]    acc_ff, acc_in;
   logic [DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0]    div_ff, div_in;
   logic [DIVISOR_W:0]      shifted;
   logic [DIVISOR_W+1:0]    diff;
   logic                    take;

   always_comb begin
      shifted = {acc_ff, quo_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      take    = !diff[DIVISOR_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         acc_in  = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/strip_peak_finder_zero_suppress.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strip_peak_finder_zero_suppress
// Strip peak finder with noise-based zero suppression and parabolic timing.
// ----------------------------------------------------------------------------
// A noise load or a sample that is not the last of its channel leaves the
// block ready, and the next item is taken in the following cycle. A last
// sample holds off the next item until the block is idle again: first the
// registered noise memory read, then the tests, and then, when a peak time is
// fitted, a shift-subtract divider that yields one quotient bit per cycle over
// 21 bits; the channel is done after the tests when it is suppressed or no
// peak time is fitted. The result waits in an output register, and a later hit
// waits for it to be taken before its tests complete. The noise memory needs
// no clearing: every channel must be loaded before its first sample arrives.
// ----------------------------------------------------------------------------
module strip_peak_finder_zero_suppress #(
   parameter int CHANNELS = spf_pkg::CHANNELS_DEF,
   parameter int SAMPLES  = spf_pkg::SAMPLES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_command,
   input  wire logic [spf_pkg::CHAN_W-1:0]           req_channel,
   input  wire logic signed [spf_pkg::AMP_W-1:0]     req_amplitude,
   input  wire logic [spf_pkg::NOISE_W-1:0]          req_noise_rms,
   input  wire logic                                 req_last_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [spf_pkg::CHAN_W-1:0]                rsp_hit_channel,
   output logic [spf_pkg::PEAK_W-1:0]                rsp_peak_amplitude,
   output logic [spf_pkg::INDEX_W-1:0]               rsp_peak_index,
   output logic signed [spf_pkg::TIME_W-1:0]         rsp_peak_time,
   output logic [spf_pkg::NOISE_W-1:0]               rsp_hit_noise,
   input  wire logic                                 csr_write,
   input  wire logic [spf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [spf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import spf_pkg::*;

   localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PosW  = $clog2(SAMPLES);
   localparam int ProdW = THR_W + NOISE_W;

   state_type state_ff, state_in;

   logic [THR_W-1:0]   thr_ff;
   logic [PEAK_W-1:0]  min_amp_ff;
   logic [NOISE_W-1:0] min_noise_ff;

   logic [NOISE_W-1:0] noise_mem [CHANNELS];
   logic [NOISE_W-1:0] rd_ff;
   logic               in_range_ff;
   logic [CHAN_W-1:0]  channel_ff;
   logic [AddrW-1:0]   addr;
   logic               in_range;

   logic               req_fire;
   logic               sample_fire;
   track_type          trk;
   logic [PosW-1:0]    trk_pos;
   logic               trk_clear;

   logic [NOISE_W-1:0]       noise;
   logic [ProdW-1:0]         limit;
   logic [ProdW-1:0]         scaled;
   logic                     pass;
   logic signed [NUM_W-1:0]  num;
   logic signed [DEN_W-1:0]  den;
   logic                     fit_ok;
   logic                     out_free;
   logic                     cap_en;
   logic                     div_start;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_quo;
   logic                     rsp_set;
   logic [TIME_W-1:0]        time_fit;

   logic                     rsp_valid_ff;
   logic [CHAN_W-1:0]        rsp_channel_ff;
   logic [PEAK_W-1:0]        rsp_amp_ff;
   logic [INDEX_W-1:0]       rsp_index_ff;
   logic [TIME_W-1:0]        rsp_time_ff;
   logic [NOISE_W-1:0]       rsp_noise_ff;
   logic [PosW-1:0]          pos_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_command == CMD_SAMPLE);
   assign addr        = AddrW'(req_channel);
   assign in_range    = 32'(req_channel) < CHANNELS;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         min_amp_ff   <= MIN_AMP_RESET;
         min_noise_ff <= MIN_NOISE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD_SIGMAS: thr_ff       <= csr_wdata[THR_W-1:0];
            REG_MIN_AMPLITUDE:    min_amp_ff   <= csr_wdata[PEAK_W-1:0];
            REG_MIN_NOISE:        min_noise_ff <= csr_wdata[NOISE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_command == CMD_LOAD) && in_range) begin
         noise_mem[addr] <= req_noise_rms;
      end
      if (req_fire) begin
         rd_ff       <= noise_mem[addr];
         in_range_ff <= in_range;
         channel_ff  <= req_channel;
      end
   end

   spf_track #(
      .SAMPLES (SAMPLES)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_fire),
      .sample    (req_amplitude),
      .clear_en  (trk_clear),
      .status    (trk),
      .max_pos   (trk_pos)
   );

   spf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num[NUM_W-2:0], 8'h00}),
      .divisor  (den[DIVISOR_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      noise    = in_range_ff ? rd_ff : '0;
      limit    = ProdW'(thr_ff) * ProdW'(noise);
      scaled   = ProdW'({trk.running_max, 8'h00});
      pass     = (scaled >= limit) && (trk.running_max > min_amp_ff)
                 && (noise > min_noise_ff);
      num      = $signed({2'b00, trk.running_max})
                 - $signed({trk.lead[AMP_W-1], trk.lead});
      den      = $signed({2'b00, trk.running_max, 1'b0})
                 - $signed({{2{trk.lead[AMP_W-1]}}, trk.lead})
                 - $signed({{2{trk.trail[AMP_W-1]}}, trk.trail});
      fit_ok   = (trk_pos != '0) && !trk.after_pending && !num[NUM_W-1]
                 && !den[DEN_W-1] && (den != '0);
      out_free = !rsp_valid_ff || rsp_ready;
      time_fit = TIME_W'({pos_ff, 8'h00}) - TIME_HALF + div_quo[TIME_W-1:0];

      state_in  = state_ff;
      trk_clear = 1'b0;
      cap_en    = 1'b0;
      div_start = 1'b0;
      rsp_set   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire && req_last_sample) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (!pass) begin
               trk_clear = 1'b1;
               state_in  = ST_IDLE;
            end else if (out_free) begin
               trk_clear = 1'b1;
               cap_en    = 1'b1;
               if (fit_ok) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  rsp_set  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_set  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cap_en) begin
         rsp_channel_ff <= channel_ff;
         rsp_amp_ff     <= trk.running_max;
         rsp_index_ff   <= INDEX_W'(trk_pos);
         rsp_noise_ff   <= noise;
         rsp_time_ff    <= TIME_NO_FIT;
         pos_ff         <= trk_pos;
      end else if ((state_ff == ST_DIV) && div_done) begin
         rsp_time_ff <= time_fit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit_channel    = rsp_channel_ff;
   assign rsp_peak_amplitude = rsp_amp_ff;
   assign rsp_peak_index     = rsp_index_ff;
   assign rsp_peak_time      = $signed(rsp_time_ff);
   assign rsp_hit_noise      = rsp_noise_ff;

endmodule
`default_nettype wire

@@ rtl/core/spf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks of the strip peak finder, bound to the top level.
// ----------------------------------------------------------------------------
module spf_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic                                 req_command,
   input  wire logic                                 req_last_sample,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic [spf_pkg::CHAN_W-1:0]           rsp_hit_channel,
   input  wire logic [spf_pkg::PEAK_W-1:0]           rsp_peak_amplitude,
   input  wire logic signed [spf_pkg::TIME_W-1:0]    rsp_peak_time
);
   import spf_pkg::*;

   logic req_fire;
   logic ends_channel;

   assign req_fire     = req_valid && req_ready;
   assign ends_channel = (req_command == CMD_SAMPLE) && req_last_sample;

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_channel)
         && $stable(rsp_peak_amplitude) && $stable(rsp_peak_time))
      else $error("item changed while stalled");

   quick_item: assert property (@(posedge clock) disable iff (reset)
      req_fire && !ends_channel |=> req_ready)
      else $error("input stalled after a single-cycle item");

   channel_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && ends_channel |=> !req_ready)
      else $error("input taken during end-of-channel tests");

   hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_amplitude != '0)
      else $error("hit with zero amplitude");

   hit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("item appeared without a finished channel");

endmodule

bind strip_peak_finder_zero_suppress spf_checker u_spf_checker (.*);
`default_nettype wire
